/* sv/sacl_pkg.sv */
// Shared types and constants of the set-associative LRU cache model.
// Used by the row memory, the way update logic and the top level.
// No dependencies.
`default_nettype none

package sacl_pkg;

	// Default sizes, handed to the top-level parameters
	localparam int SETS_DEF     = 256;
	localparam int WAYS_DEF     = 8;
	localparam int TAG_BITS_DEF = 32;

	// Field widths
	localparam int KIND_W    = 2;
	localparam int ADDR_W    = 64;
	localparam int STATUS_W  = 2;
	localparam int TOTAL_W   = 32;
	localparam int IN_DATA_W = 64;
	localparam int OUT_DATA_W = 104;

	// Configuration register widths and reset values
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 5;
	localparam int SET_WID_W   = 4;
	localparam int BLK_BITS_W  = 5;
	localparam int WAYS_CFG_W  = 4;
	localparam logic [SET_WID_W-1:0]  SET_WID_RST  = 4'd4;
	localparam logic [BLK_BITS_W-1:0] BLK_BITS_RST = 5'd4;
	localparam logic [WAYS_CFG_W-1:0] WAYS_CFG_RST = 4'd1;

	// Width of the raw set field (the set index width is at most 15)
	localparam int SIDX_W = 15;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_SET_WIDTH    = 2'd0,
		CFG_OFFSET_WIDTH = 2'd1,
		CFG_WAYS_IN_USE  = 2'd2
	} sacl_cfg_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_LOAD   = 2'd0,
		KIND_STORE  = 2'd1,
		KIND_MODIFY = 2'd2
	} sacl_kind_t;

	typedef enum logic [STATUS_W-1:0] {
		STAT_HIT   = 2'd0,
		STAT_MISS  = 2'd1,
		STAT_EVICT = 2'd2
	} sacl_status_t;

	typedef enum logic [1:0] {
		ST_CLEAR  = 2'd0,
		ST_IDLE   = 2'd1,
		ST_READ   = 2'd2,
		ST_UPDATE = 2'd3
	} sacl_state_t;

endpackage

`default_nettype wire

/* sv/sacl_row_mem.sv */
// Set row memory: one row per set holding valid, tag and rank of every way.
// Single write port, single read port, read data registered.
// Depends on sacl_pkg.
`default_nettype none

module sacl_row_mem import sacl_pkg::*; #(
	parameter int DEPTH  = SETS_DEF,
	parameter int ADDR_W = 8,
	parameter int ROW_W  = 288
) (
	input  wire logic              clk,
	input  wire logic              we,
	input  wire logic [ADDR_W-1:0] waddr,
	input  wire logic [ROW_W-1:0]  wdata,
	input  wire logic              re,
	input  wire logic [ADDR_W-1:0] raddr,
	output logic      [ROW_W-1:0]  rdata
);

	logic [ROW_W-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

/* sv/sacl_way_update.sv */
// Lookup and LRU update of one set row: hit search, fill or victim pick,
// and rank aging. Purely combinational, sits between row read and write-back.
// Depends on sacl_pkg.
`default_nettype none

module sacl_way_update import sacl_pkg::*; #(
	parameter int WAYS     = WAYS_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input  wire logic [WAYS*(1+TAG_BITS+((WAYS>1)?$clog2(WAYS):1))-1:0] row_rd,
	input  wire logic [TAG_BITS-1:0]                                    tag,
	input  wire logic [$clog2(WAYS+1)-1:0]                              nways,
	output logic      [WAYS*(1+TAG_BITS+((WAYS>1)?$clog2(WAYS):1))-1:0] row_wr,
	output sacl_status_t                                                status
);

	localparam int RANK_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int WAY_W  = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int NW_W   = $clog2(WAYS + 1);
	localparam int ENT_W  = 1 + TAG_BITS + RANK_W;
	localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(WAYS - 1);

	logic                valid [WAYS];
	logic [TAG_BITS-1:0] tags  [WAYS];
	logic [RANK_W-1:0]   ranks [WAYS];
	logic                in_use [WAYS];

	logic             hit, free;
	logic [WAY_W-1:0] hit_way, free_way, victim, target;
	logic [RANK_W-1:0] old_rank;
	logic             fresh;

	// unpack the row and search it
	always_comb begin
		hit      = 1'b0;
		free     = 1'b0;
		hit_way  = '0;
		free_way = '0;
		victim   = '0;
		for (int w = 0; w < WAYS; w++) begin
			valid[w]  = row_rd[w*ENT_W];
			tags[w]   = row_rd[w*ENT_W+1 +: TAG_BITS];
			ranks[w]  = row_rd[w*ENT_W+1+TAG_BITS +: RANK_W];
			in_use[w] = (NW_W'(w) < nways);
		end
		// descending, so the lowest-numbered match wins
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (in_use[w] && valid[w] && (tags[w] == tag)) begin
				hit     = 1'b1;
				hit_way = WAY_W'(w);
			end
			if (in_use[w] && !valid[w]) begin
				free     = 1'b1;
				free_way = WAY_W'(w);
			end
		end
		// oldest way, lowest index on ties
		for (int w = 1; w < WAYS; w++) begin
			if (in_use[w] && (ranks[w] > ranks[victim])) begin
				victim = WAY_W'(w);
			end
		end
	end

	// pick the way to touch and build the new row
	always_comb begin
		if (hit) begin
			target = hit_way;
			status = STAT_HIT;
		end else if (free) begin
			target = free_way;
			status = STAT_MISS;
		end else begin
			target = victim;
			status = STAT_EVICT;
		end
		fresh    = !hit && free;
		old_rank = ranks[target];
		row_wr   = row_rd;
		for (int v = 0; v < WAYS; v++) begin
			if (WAY_W'(v) == target) begin
				row_wr[v*ENT_W +: ENT_W] = {{RANK_W{1'b0}}, tag, 1'b1};
			end else if (in_use[v] && valid[v] && (fresh || (ranks[v] < old_rank))
					&& (ranks[v] < RANK_MAX)) begin
				row_wr[v*ENT_W+1+TAG_BITS +: RANK_W] = ranks[v] + RANK_W'(1);
			end
		end
	end

endmodule

`default_nettype wire

/* sv/set_assoc_lru_cache_sim.sv */
// Set-associative cache tag model with true LRU, one result beat per access.
// The result beat is registered in the write-back state, after the row read.
// Accesses do not overlap (accept, row read, row write-back; the next access waits for the
// write-back); a stalled output holds the write-back.
// Reset: the set memory is cleared row by row, no input is taken meanwhile;
// configuration returns to set index width 4, offset width 4, one way.
`default_nettype none

module set_assoc_lru_cache_sim import sacl_pkg::*; #(
	parameter int SETS     = SETS_DEF,
	parameter int WAYS     = WAYS_DEF,
	parameter int TAG_BITS = TAG_BITS_DEF
) (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// configuration
	input  wire logic                  cfg_we,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
	// access stream
	input  wire logic                  s_tvalid,
	output logic                       s_tready,
	input  wire logic [IN_DATA_W-1:0]  s_tdata,   // [63:0] address
	input  wire logic [KIND_W-1:0]     s_tuser,   // [1:0] kind
	// result stream
	output logic                       m_tvalid,
	input  wire logic                  m_tready,
	output logic      [OUT_DATA_W-1:0] m_tdata    // [1:0] status, [2] second_hit,
	                                              // [34:3] hit_total, [66:35] miss_total,
	                                              // [98:67] eviction_total, [103:99] zero
);

	localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
	localparam int SET_L    = $clog2(SETS);
	localparam int RANK_W   = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int NW_W     = $clog2(WAYS + 1);
	localparam int ROW_W    = WAYS * (1 + TAG_BITS + RANK_W);
	// exact reciprocal for set_field / SETS over SIDX_W-bit values
	localparam int RECIP_SH = SIDX_W + SET_L;
	localparam int RECIP_W  = SIDX_W + 2;
	localparam int PROD_W   = RECIP_SH + SIDX_W;
	localparam logic [RECIP_W-1:0] RECIP =
		RECIP_W'(((64'd1 << RECIP_SH) + 64'(SETS) - 64'd1) / 64'(SETS));
	localparam logic [SET_W-1:0] CLR_LAST = SET_W'(SETS - 1);

	sacl_state_t state_q, state_nx;

	logic [SET_WID_W-1:0]  set_width_q;
	logic [BLK_BITS_W-1:0] offset_width_q;
	logic [WAYS_CFG_W-1:0] ways_q;

	logic [SET_W-1:0]    clr_q;
	logic [KIND_W-1:0]   kind_s1;
	logic [TAG_BITS-1:0] tag_s1;
	logic [SIDX_W-1:0]   sfield_s1;
	logic [SIDX_W-1:0]   quot_s1;
	logic [SET_W-1:0]    set_s2;

	logic [TOTAL_W-1:0] hit_q, miss_q, evict_q;
	logic               out_valid_q;
	logic [OUT_DATA_W-1:0] out_data_q;

	// index stage
	logic [ADDR_W-1:0] addr_blk, addr_tag;
	logic [15:0]       set_mask;
	logic [SIDX_W-1:0] sfield;
	logic [PROD_W-1:0] quot_prod;
	logic [SIDX_W-1:0] rem_prod;
	logic [SIDX_W-1:0] rem_full;
	logic [SET_W-1:0]  set_idx;

	// memory and update
	logic               mem_we, mem_re;
	logic [SET_W-1:0]   mem_waddr;
	logic [ROW_W-1:0]   mem_wdata, row_rd, row_wr;
	logic [NW_W-1:0]    nways;
	sacl_status_t       upd_status;

	// output side
	logic               out_free, out_load, access;
	logic [1:0]         hit_inc;
	logic [STATUS_W-1:0] res_status;
	logic               res_second;
	logic [TOTAL_W-1:0] hit_nx, miss_nx, evict_nx;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			set_width_q    <= SET_WID_RST;
			offset_width_q <= BLK_BITS_RST;
			ways_q         <= WAYS_CFG_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_SET_WIDTH:    set_width_q    <= cfg_wdata[SET_WID_W-1:0];
				CFG_OFFSET_WIDTH: offset_width_q <= cfg_wdata[BLK_BITS_W-1:0];
				CFG_WAYS_IN_USE:  ways_q         <= cfg_wdata[WAYS_CFG_W-1:0];
				default: ;
			endcase
		end
	end

	// clamp ways in use to 1..WAYS
	always_comb begin
		if (ways_q == '0) begin
			nways = NW_W'(1);
		end else if (int'(ways_q) > WAYS) begin
			nways = NW_W'(WAYS);
		end else begin
			nways = NW_W'(ways_q);
		end
	end

	// address split and quotient at accept time
	always_comb begin
		addr_blk  = s_tdata >> offset_width_q;
		addr_tag  = s_tdata >> ({2'b00, set_width_q} + {1'b0, offset_width_q});
		set_mask  = (16'd1 << set_width_q) - 16'd1;
		sfield    = addr_blk[SIDX_W-1:0] & set_mask[SIDX_W-1:0];
		quot_prod = PROD_W'(sfield) * PROD_W'(RECIP);
	end

	// remainder in the read stage
	always_comb begin
		rem_prod = SIDX_W'(quot_s1 * SIDX_W'(SETS));
		rem_full = sfield_s1 - rem_prod;
		set_idx  = rem_full[SET_W-1:0];
	end

	// stage registers
	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1   <= s_tuser;
			tag_s1    <= addr_tag[TAG_BITS-1:0];
			sfield_s1 <= sfield;
			quot_s1   <= quot_prod[RECIP_SH +: SIDX_W];
		end
		if (state_q == ST_READ) begin
			set_s2 <= set_idx;
		end
	end

	// state register and clear counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
		end else begin
			state_q <= state_nx;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + SET_W'(1);
			end
		end
	end

	assign out_free = !out_valid_q || m_tready;
	assign access   = (kind_s1 == KIND_LOAD) || (kind_s1 == KIND_STORE)
	               || (kind_s1 == KIND_MODIFY);

	// next state
	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_CLEAR:  if (clr_q == CLR_LAST) state_nx = ST_IDLE;
			ST_IDLE:   if (s_tvalid) state_nx = ST_READ;
			ST_READ:   state_nx = ST_UPDATE;
			ST_UPDATE: if (out_free) state_nx = ST_IDLE;
			default:   state_nx = ST_CLEAR;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready  = 1'b0;
		mem_re    = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = set_s2;
		mem_wdata = row_wr;
		out_load  = 1'b0;
		case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			ST_IDLE: begin
				s_tready = 1'b1;
			end
			ST_READ: begin
				mem_re = 1'b1;
			end
			ST_UPDATE: begin
				out_load = out_free;
				mem_we   = out_free && access;
			end
			default: ;
		endcase
	end

	sacl_row_mem #(
		.DEPTH  (SETS),
		.ADDR_W (SET_W),
		.ROW_W  (ROW_W)
	) u_row_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.re    (mem_re),
		.raddr (set_idx),
		.rdata (row_rd)
	);

	sacl_way_update #(
		.WAYS     (WAYS),
		.TAG_BITS (TAG_BITS)
	) u_way_update (
		.row_rd (row_rd),
		.tag    (tag_s1),
		.nways  (nways),
		.row_wr (row_wr),
		.status (upd_status)
	);

	// result fields and running totals
	always_comb begin
		res_status = access ? upd_status : STAT_HIT;
		res_second = (kind_s1 == KIND_MODIFY);
		hit_inc    = {1'b0, access && (upd_status == STAT_HIT)} + {1'b0, res_second};
		hit_nx     = hit_q + TOTAL_W'(hit_inc);
		miss_nx    = miss_q + TOTAL_W'(access && (upd_status != STAT_HIT));
		evict_nx   = evict_q + TOTAL_W'(access && (upd_status == STAT_EVICT));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_q       <= '0;
			miss_q      <= '0;
			evict_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_load) begin
				hit_q   <= hit_nx;
				miss_q  <= miss_nx;
				evict_q <= evict_nx;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_data_q <= {5'd0, evict_nx, miss_nx, hit_nx, res_second, res_status};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// checks
	a_no_input_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CLEAR) |-> !s_tready)
		else $error("input taken during memory clear");

	a_totals_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!out_load |=> ($stable(miss_q) && $stable(evict_q) && $stable(hit_q)))
		else $error("totals moved without a result");

	a_hit_step: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> ((hit_q - $past(hit_q)) <= 32'd2))
		else $error("hit total stepped by more than two");

	a_evict_is_miss: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> ((evict_q - $past(evict_q)) <= (miss_q - $past(miss_q))))
		else $error("eviction counted without a miss");

	a_no_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |-> !out_load)
		else $error("result overwritten while stalled");

endmodule

`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 100ps
// Testbench for the set-associative LRU cache tag model: bursty access beats in, stalled
// result beats out, each result checked against a shadow copy of the sets and totals.
// Depends on sacl_pkg and set_assoc_lru_cache_sim.

module testbench;
	import sacl_pkg::*;

	localparam int RANK_W = $clog2(WAYS_DEF);
	localparam logic [KIND_W-1:0] KIND_NONE = 2'd3;   // kind that makes no access
	localparam int SETTLE      = 4;                    // cycles past the last result
	localparam int HOLD_AT     = 300;                  // results seen before the long stall
	localparam int HOLD_LEN    = 250;
	localparam int QUIET_LIMIT = 2000;                 // cycles without any beat
	localparam int PHASE_ITEMS = 165;

	// one result beat, lowest field last
	typedef struct packed {
		logic [TOTAL_W-1:0] evictions;
		logic [TOTAL_W-1:0] misses;
		logic [TOTAL_W-1:0] hits;
		logic               second_hit;
		sacl_status_t       status;
	} cache_result_t;

	// Shadow of the tag store, LRU ranks and totals; queues the expected result beats
	class cache_shadow;
		bit                    line_ok   [SETS_DEF*WAYS_DEF];
		bit [TAG_BITS_DEF-1:0] line_tag  [SETS_DEF*WAYS_DEF];
		bit [RANK_W-1:0]       line_rank [SETS_DEF*WAYS_DEF];
		bit [TOTAL_W-1:0]      hits = '0;
		bit [TOTAL_W-1:0]      misses = '0;
		bit [TOTAL_W-1:0]      evictions = '0;
		int unsigned           set_width = SET_WID_RST;
		int unsigned           offset_width = BLK_BITS_RST;
		int unsigned           ways_cfg = WAYS_CFG_RST;
		cache_result_t         due_results[$];
		int unsigned           checked = 0;
		int unsigned           faults = 0;

		function void write_reg(sacl_cfg_t idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
				CFG_SET_WIDTH:    set_width = 32'(val & 5'h0F);
				CFG_OFFSET_WIDTH: offset_width = 32'(val);
				CFG_WAYS_IN_USE:  ways_cfg = 32'(val & 5'h0F);
				default: ;
			endcase
		endfunction

		function int unsigned live_ways();
			if (ways_cfg == 0)
				return 1;
			if (ways_cfg > WAYS_DEF)
				return WAYS_DEF;
			return ways_cfg;
		endfunction

		function int unsigned pending();
			return due_results.size();
		endfunction

		// make way w most recent; fresh means it held no valid line
		function void promote(int unsigned base, int unsigned nways, int unsigned w, bit fresh);
			bit [RANK_W-1:0] old;
			int unsigned v;
			old = line_rank[base + w];
			for (v = 0; v < nways; v++) begin
				if (v != w && line_ok[base + v] && (fresh || line_rank[base + v] < old) &&
				    line_rank[base + v] < WAYS_DEF - 1)
					line_rank[base + v]++;
			end
			line_rank[base + w] = '0;
		endfunction

		function sacl_status_t lookup(logic [ADDR_W-1:0] addr);
			logic [ADDR_W-1:0]     set_field;
			bit [TAG_BITS_DEF-1:0] tag_now;
			int unsigned nways, base, w, victim;
			nways = live_ways();
			set_field = (addr >> offset_width) & ((64'd1 << set_width) - 64'd1);
			base = 32'((set_field % SETS_DEF) * WAYS_DEF);
			tag_now = TAG_BITS_DEF'(addr >> (set_width + offset_width));
			for (w = 0; w < nways; w++) begin
				if (line_ok[base + w] && line_tag[base + w] == tag_now) begin
					promote(base, nways, w, 1'b0);
					return STAT_HIT;
				end
			end
			for (w = 0; w < nways; w++) begin
				if (!line_ok[base + w]) begin
					line_ok[base + w] = 1'b1;
					line_tag[base + w] = tag_now;
					promote(base, nways, w, 1'b1);
					return STAT_MISS;
				end
			end
			// oldest way goes, lowest index on a tie
			victim = 0;
			for (w = 1; w < nways; w++) begin
				if (line_rank[base + w] > line_rank[base + victim])
					victim = w;
			end
			line_tag[base + victim] = tag_now;
			promote(base, nways, victim, 1'b0);
			return STAT_EVICT;
		endfunction

		function void note_access(logic [KIND_W-1:0] kind, logic [ADDR_W-1:0] addr);
			cache_result_t r;
			r.status = STAT_HIT;
			r.second_hit = 1'b0;
			if (kind != KIND_NONE) begin
				r.status = lookup(addr);
				if (r.status == STAT_HIT) begin
					hits++;
				end else begin
					misses++;
					if (r.status == STAT_EVICT)
						evictions++;
				end
				// store half of a modify always hits
				if (kind == KIND_MODIFY) begin
					r.second_hit = 1'b1;
					hits++;
				end
			end
			r.hits = hits;
			r.misses = misses;
			r.evictions = evictions;
			due_results.push_back(r);
		endfunction

		function void check_result(logic [OUT_DATA_W-1:0] beat);
			cache_result_t want, got;
			got = cache_result_t'(beat[$bits(cache_result_t)-1:0]);
			checked++;
			if (due_results.size() == 0) begin
				$error("result beat with no access outstanding");
				faults++;
				return;
			end
			want = due_results.pop_front();
			if (got.status !== want.status) begin
				$error("status: expected %0d, got %0d", want.status, got.status);
				faults++;
			end
			if (got.second_hit !== want.second_hit) begin
				$error("second_hit: expected %0d, got %0d", want.second_hit, got.second_hit);
				faults++;
			end
			if (got.hits !== want.hits) begin
				$error("hit_total: expected %0d, got %0d", want.hits, got.hits);
				faults++;
			end
			if (got.misses !== want.misses) begin
				$error("miss_total: expected %0d, got %0d", want.misses, got.misses);
				faults++;
			end
			if (got.evictions !== want.evictions) begin
				$error("eviction_total: expected %0d, got %0d", want.evictions, got.evictions);
				faults++;
			end
		endfunction
	endclass

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic                  s_tvalid = 1'b0;
	logic                  s_tready;
	logic [IN_DATA_W-1:0]  s_tdata = '0;    // [63:0] address
	logic [KIND_W-1:0]     s_tuser = '0;    // [1:0] kind
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;         // [1:0] status, [2] second_hit, [34:3] hit_total,
	                                        // [66:35] miss_total, [98:67] eviction_total

	cache_shadow       book = new;
	int unsigned       burst_left = 1;
	int unsigned       quiet_cycles = 0;
	logic [ADDR_W-1:0] tag_base = '0;

	set_assoc_lru_cache_sim dut (
		.clk, .arst_n,
		.cfg_we, .cfg_index, .cfg_wdata,
		.s_tvalid, .s_tready, .s_tdata, .s_tuser,
		.m_tvalid, .m_tready, .m_tdata
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// offer one access beat and hold it until taken
	task automatic push_access(input logic [KIND_W-1:0] kind, input logic [ADDR_W-1:0] addr);
		s_tvalid <= 1'b1;
		s_tdata  <= addr;
		s_tuser  <= kind;
		do @(posedge clk); while (s_tready !== 1'b1);
		book.note_access(kind, addr);
	endtask

	// bursts of random length, random gaps between them
	task automatic pace();
		int unsigned gap;
		if (burst_left > 1) begin
			burst_left--;
			return;
		end
		burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 80) : $urandom_range(1, 12);
		gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
		if (gap != 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// stop offering and wait for every outstanding result, then let the write-back finish
	task automatic drain();
		s_tvalid <= 1'b0;
		while (book.pending() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic configure(input logic [CFG_DATA_W-1:0] sb, input logic [CFG_DATA_W-1:0] bb,
	                         input logic [CFG_DATA_W-1:0] ways);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_SET_WIDTH;
		cfg_wdata <= sb;
		@(posedge clk);
		book.write_reg(CFG_SET_WIDTH, sb);
		cfg_index <= CFG_OFFSET_WIDTH;
		cfg_wdata <= bb;
		@(posedge clk);
		book.write_reg(CFG_OFFSET_WIDTH, bb);
		cfg_index <= CFG_WAYS_IN_USE;
		cfg_wdata <= ways;
		@(posedge clk);
		book.write_reg(CFG_WAYS_IN_USE, ways);
		cfg_we <= 1'b0;
	endtask

	function automatic logic [KIND_W-1:0] pick_kind();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 30)
			return KIND_LOAD;
		if (roll < 60)
			return KIND_STORE;
		if (roll < 94)
			return KIND_MODIFY;
		return KIND_NONE;
	endfunction

	// mostly a small pool of tags over a few sets, so lines get reused and evicted
	function automatic logic [ADDR_W-1:0] pick_address();
		logic [ADDR_W-1:0] tag_part, set_part, offset;
		int unsigned lo;
		if ($urandom_range(0, 99) < 12)
			return {$urandom, $urandom};
		lo = book.set_width + book.offset_width;
		tag_part = tag_base + $urandom_range(0, book.live_ways() + 2);
		set_part = {32'd0, $urandom_range(0, 3)};
		// high set bits fold onto the same set when the index is past the set count
		if ($urandom_range(0, 3) == 0)
			set_part = set_part | ({32'd0, $urandom_range(1, 127)} << 8);
		set_part = set_part & ((64'd1 << book.set_width) - 64'd1);
		offset = {$urandom, $urandom} & ((64'd1 << book.offset_width) - 64'd1);
		tag_part = tag_part << lo;
		// junk above the tag field must not change the tag
		if ($urandom_range(0, 7) == 0 && lo + TAG_BITS_DEF < ADDR_W)
			tag_part = tag_part | ({$urandom, $urandom} << (lo + TAG_BITS_DEF));
		return tag_part | (set_part << book.offset_width) | offset;
	endfunction

	task automatic run_phase(input int unsigned count);
		int unsigned n;
		for (n = 0; n < count; n++) begin
			push_access(pick_kind(), pick_address());
			if (n + 1 < count)
				pace();
		end
		drain();
	endtask

	// Stimulus
	initial begin : stimulus
		int unsigned plan [8][3];
		int unsigned p;
		plan = '{'{0, 16, 8}, '{8, 6, 8}, '{3, 31, 15}, '{15, 5, 0},
		         '{12, 2, 2}, '{1, 4, 3}, '{4, 4, 5}, '{6, 1, 1}};
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset settings: 16 sets, 16-byte blocks, direct mapped
		push_access(KIND_LOAD, 64'h0);                      // cold miss
		push_access(KIND_LOAD, 64'h8);                      // same block, hit
		push_access(KIND_STORE, 64'hFFFF_FFFF_FFFF_FFFF);   // top set, all-ones tag
		push_access(KIND_MODIFY, 64'hFFFF_FFFF_FFFF_FFFF);  // hit plus store hit
		push_access(KIND_LOAD, 64'h100);                    // same set, new tag: evict
		push_access(KIND_NONE, 64'hFFFF_FFFF_FFFF_FFFF);    // no access
		push_access(KIND_STORE, 64'h0);                     // evict back
		push_access(KIND_NONE, 64'h0);
		drain();

		// four ways over four sets, no block offset
		configure(5'd2, 5'd0, 5'd4);
		push_access(KIND_LOAD, 64'h0);
		push_access(KIND_STORE, 64'h4);
		push_access(KIND_MODIFY, 64'h8);
		push_access(KIND_LOAD, 64'hC);                      // set 0 now full
		push_access(KIND_LOAD, 64'h0);                      // hit, tag 0 most recent
		push_access(KIND_LOAD, 64'h10);                     // evicts tag 1
		push_access(KIND_STORE, 64'h4);                     // evicts tag 2
		push_access(KIND_MODIFY, 64'h8);                    // evicts tag 3
		push_access(KIND_LOAD, 64'h0);
		drain();

		// random phases; ways change without a flush, so ranks may tie
		for (p = 0; p < 8; p++) begin
			configure(5'(plan[p][0]), 5'(plan[p][1]), 5'(plan[p][2]));
			tag_base = {32'd0, $urandom};
			run_phase(PHASE_ITEMS);
		end

		if (book.faults == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

	// Result side stalls: a repeating pattern, plus one long hold-off mid-run
	initial begin : receiver
		int unsigned tick;
		int unsigned hold;
		bit held;
		tick = 0;
		hold = 0;
		held = 1'b0;
		forever begin
			@(posedge clk);
			tick++;
			if (!held && book.checked >= HOLD_AT) begin
				hold = HOLD_LEN;
				held = 1'b1;
			end
			if (hold != 0) begin
				hold--;
				m_tready <= 1'b0;
			end else begin
				case ((tick / 64) % 4)
					0: m_tready <= 1'b1;
					1: m_tready <= 1'($urandom_range(0, 1));
					2: m_tready <= ($urandom_range(0, 3) == 0);
					default: m_tready <= ($urandom_range(0, 7) != 0);
				endcase
			end
		end
	end

	// Result monitor
	always @(posedge clk) begin
		if (m_tvalid === 1'b1 && m_tready)
			book.check_result(m_tdata);
	end

	// Watchdog: too long with no beat on either side
	always @(posedge clk) begin
		if ((s_tvalid && s_tready === 1'b1) || (m_tvalid === 1'b1 && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("FAILURE");
			$finish;
		end
	end

endmodule
